// ===== design/zaf_pkg.sv =====
// Shared types, operation codes and flag bit positions for the Z80 ALU flag unit.
package zaf_pkg;

   // Operation codes carried in the opcode field.
   localparam logic [4:0] OP_ADD8  = 5'd0;
   localparam logic [4:0] OP_ADC8  = 5'd1;
   localparam logic [4:0] OP_SUB8  = 5'd2;
   localparam logic [4:0] OP_SBC8  = 5'd3;
   localparam logic [4:0] OP_INC8  = 5'd4;
   localparam logic [4:0] OP_DEC8  = 5'd5;
   localparam logic [4:0] OP_RLC   = 5'd6;
   localparam logic [4:0] OP_RRC   = 5'd7;
   localparam logic [4:0] OP_RL    = 5'd8;
   localparam logic [4:0] OP_RR    = 5'd9;
   localparam logic [4:0] OP_SLA   = 5'd10;
   localparam logic [4:0] OP_SRA   = 5'd11;
   localparam logic [4:0] OP_SLL   = 5'd12;
   localparam logic [4:0] OP_SRL   = 5'd13;
   localparam logic [4:0] OP_DAA   = 5'd14;
   localparam logic [4:0] OP_ADD16 = 5'd15;
   localparam logic [4:0] OP_WIDE  = 5'd16;

   // Bit positions inside the flag byte.
   localparam int FLAG_S  = 7;
   localparam int FLAG_Z  = 6;
   localparam int FLAG_5  = 5;
   localparam int FLAG_H  = 4;
   localparam int FLAG_3  = 3;
   localparam int FLAG_PV = 2;
   localparam int FLAG_N  = 1;
   localparam int FLAG_C  = 0;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_LO_FIX   = 8'h06;
   localparam logic [7:0] DAA_HI_FIX   = 8'h60;
   localparam logic [8:0] DAA_HI_LIMIT = 9'h09F;
   localparam logic [3:0] DAA_DIGIT_MAX = 4'd9;

   // Increment and decrement overflow operands.
   localparam logic [7:0] INC_OVF_OPERAND = 8'h7F;
   localparam logic [7:0] DEC_OVF_OPERAND = 8'h80;

   // One input item.
   typedef struct packed {
      logic [4:0]  opcode;
      logic        wide_subtract;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic        carry_in;
      logic [7:0]  flags_in;
   } zaf_req_type;

   // One result item.
   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  flags_out;
   } zaf_rsp_type;

endpackage

// ===== design/zaf_alu.sv =====
// Combinational datapath: result value and flag byte for one item.
module zaf_alu (
   input  zaf_pkg::zaf_req_type req,
   output zaf_pkg::zaf_rsp_type rsp
);
   import zaf_pkg::*;

   // S, Z, F5 and F3 of an 8-bit value.
   function automatic logic [7:0] sz53(input logic [7:0] r);
      logic [7:0] f;
      f         = 8'h00;
      f[FLAG_S] = r[7];
      f[FLAG_5] = r[5];
      f[FLAG_3] = r[3];
      f[FLAG_Z] = (r == 8'h00);
      return f;
   endfunction

   // S, Z, F5, F3 and even parity of an 8-bit value.
   function automatic logic [7:0] sz53p(input logic [7:0] r);
      logic [7:0] f;
      f          = sz53(r);
      f[FLAG_PV] = ~^r;
      return f;
   endfunction

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        c8;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  dif9;
   logic [4:0]  hdif5;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic        c16;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [16:0] dif17;
   logic [12:0] hdif13;
   logic        daa_n;
   logic        daa_h;
   logic        daa_c;
   logic        daa_lo_adj;
   logic [8:0]  daa_t9;
   logic        daa_hi_adj;
   logic [7:0]  daa_add_res;
   logic [7:0]  daa_sub_res;
   logic [7:0]  sh_res;
   logic        sh_out;

   assign a8 = req.operand_a[7:0];
   assign b8 = req.operand_b[7:0];

   // Carry taken only by the with-carry forms.
   assign c8  = ((req.opcode == OP_ADC8) || (req.opcode == OP_SBC8)) ? req.carry_in : 1'b0;
   assign c16 = (req.opcode == OP_WIDE) ? req.carry_in : 1'b0;

   // 8-bit adder and subtractor with nibble carries.
   assign sum9  = {1'b0, a8} + {1'b0, b8} + {8'd0, c8};
   assign hsum5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, c8};
   assign dif9  = {1'b0, a8} - {1'b0, b8} - {8'd0, c8};
   assign hdif5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, c8};
   assign inc8  = a8 + 8'd1;
   assign dec8  = a8 - 8'd1;

   // 16-bit adder and subtractor with carries out of bit 11.
   assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b} + {16'd0, c16};
   assign hsum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]} + {12'd0, c16};
   assign dif17  = {1'b0, req.operand_a} - {1'b0, req.operand_b} - {16'd0, c16};
   assign hdif13 = {1'b0, req.operand_a[11:0]} - {1'b0, req.operand_b[11:0]} - {12'd0, c16};

   // Decimal adjust: on add, low digit fix, then high fix on the adjusted value.
   assign daa_n       = req.flags_in[FLAG_N];
   assign daa_h       = req.flags_in[FLAG_H];
   assign daa_c       = req.flags_in[FLAG_C];
   assign daa_lo_adj  = daa_h || (a8[3:0] > DAA_DIGIT_MAX);
   assign daa_t9      = {1'b0, a8} + (daa_lo_adj ? {1'b0, DAA_LO_FIX} : 9'd0);
   assign daa_hi_adj  = daa_c || (daa_t9 > DAA_HI_LIMIT);
   assign daa_add_res = daa_t9[7:0] + (daa_hi_adj ? DAA_HI_FIX : 8'h00);
   assign daa_sub_res = a8 - (daa_h ? DAA_LO_FIX : 8'h00) - (daa_c ? DAA_HI_FIX : 8'h00);

   // Shift and rotate network.
   always_comb begin
      unique case (req.opcode)
         OP_RLC: begin
            sh_res = {a8[6:0], a8[7]};
            sh_out = a8[7];
         end
         OP_RRC: begin
            sh_res = {a8[0], a8[7:1]};
            sh_out = a8[0];
         end
         OP_RL: begin
            sh_res = {a8[6:0], req.carry_in};
            sh_out = a8[7];
         end
         OP_RR: begin
            sh_res = {req.carry_in, a8[7:1]};
            sh_out = a8[0];
         end
         OP_SLA: begin
            sh_res = {a8[6:0], 1'b0};
            sh_out = a8[7];
         end
         OP_SRA: begin
            sh_res = {a8[7], a8[7:1]};
            sh_out = a8[0];
         end
         OP_SLL: begin
            sh_res = {a8[6:0], 1'b1};
            sh_out = a8[7];
         end
         default: begin
            sh_res = {1'b0, a8[7:1]};
            sh_out = a8[0];
         end
      endcase
   end

   // Result and flag selection by operation.
   always_comb begin
      rsp.result    = 16'h0000;
      rsp.flags_out = req.flags_in;
      unique case (req.opcode)
         OP_ADD8, OP_ADC8: begin
            rsp.result             = {8'h00, sum9[7:0]};
            rsp.flags_out          = sz53(sum9[7:0]);
            rsp.flags_out[FLAG_H]  = hsum5[4];
            rsp.flags_out[FLAG_C]  = sum9[8];
            rsp.flags_out[FLAG_PV] = ~(a8[7] ^ b8[7]) & (sum9[7] ^ a8[7]);
         end
         OP_SUB8, OP_SBC8: begin
            rsp.result             = {8'h00, dif9[7:0]};
            rsp.flags_out          = sz53(dif9[7:0]);
            rsp.flags_out[FLAG_N]  = 1'b1;
            rsp.flags_out[FLAG_H]  = hdif5[4];
            rsp.flags_out[FLAG_C]  = dif9[8];
            rsp.flags_out[FLAG_PV] = (a8[7] ^ b8[7]) & (a8[7] ^ dif9[7]);
         end
         OP_INC8: begin
            rsp.result             = {8'h00, inc8};
            rsp.flags_out          = sz53(inc8);
            rsp.flags_out[FLAG_C]  = req.flags_in[FLAG_C];
            rsp.flags_out[FLAG_H]  = (a8[3:0] == 4'hF);
            rsp.flags_out[FLAG_PV] = (a8 == INC_OVF_OPERAND);
         end
         OP_DEC8: begin
            rsp.result             = {8'h00, dec8};
            rsp.flags_out          = sz53(dec8);
            rsp.flags_out[FLAG_N]  = 1'b1;
            rsp.flags_out[FLAG_C]  = req.flags_in[FLAG_C];
            rsp.flags_out[FLAG_H]  = (a8[3:0] == 4'h0);
            rsp.flags_out[FLAG_PV] = (a8 == DEC_OVF_OPERAND);
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
            rsp.result            = {8'h00, sh_res};
            rsp.flags_out         = sz53p(sh_res);
            rsp.flags_out[FLAG_C] = sh_out;
         end
         OP_DAA: begin
            if (daa_n) begin
               rsp.result            = {8'h00, daa_sub_res};
               rsp.flags_out         = sz53p(daa_sub_res);
               rsp.flags_out[FLAG_H] = daa_h;
               rsp.flags_out[FLAG_C] = daa_c;
            end else begin
               rsp.result            = {8'h00, daa_add_res};
               rsp.flags_out         = sz53p(daa_add_res);
               rsp.flags_out[FLAG_H] = daa_lo_adj;
               rsp.flags_out[FLAG_C] = daa_hi_adj;
            end
            rsp.flags_out[FLAG_N] = daa_n;
         end
         OP_ADD16: begin
            rsp.result             = sum17[15:0];
            rsp.flags_out          = 8'h00;
            rsp.flags_out[FLAG_S]  = req.flags_in[FLAG_S];
            rsp.flags_out[FLAG_Z]  = req.flags_in[FLAG_Z];
            rsp.flags_out[FLAG_PV] = req.flags_in[FLAG_PV];
            rsp.flags_out[FLAG_5]  = sum17[13];
            rsp.flags_out[FLAG_3]  = sum17[11];
            rsp.flags_out[FLAG_H]  = hsum13[12];
            rsp.flags_out[FLAG_C]  = sum17[16];
         end
         OP_WIDE: begin
            rsp.flags_out = 8'h00;
            if (req.wide_subtract) begin
               rsp.result             = dif17[15:0];
               rsp.flags_out[FLAG_N]  = 1'b1;
               rsp.flags_out[FLAG_H]  = hdif13[12];
               rsp.flags_out[FLAG_C]  = dif17[16];
               rsp.flags_out[FLAG_PV] = (req.operand_a[15] ^ req.operand_b[15])
                                      & (req.operand_a[15] ^ dif17[15]);
            end else begin
               rsp.result             = sum17[15:0];
               rsp.flags_out[FLAG_H]  = hsum13[12];
               rsp.flags_out[FLAG_C]  = sum17[16];
               rsp.flags_out[FLAG_PV] = ~(req.operand_a[15] ^ req.operand_b[15])
                                      & (sum17[15] ^ req.operand_a[15]);
            end
            rsp.flags_out[FLAG_S] = rsp.result[15];
            rsp.flags_out[FLAG_Z] = (rsp.result == 16'h0000);
            rsp.flags_out[FLAG_5] = rsp.result[13];
            rsp.flags_out[FLAG_3] = rsp.result[11];
         end
         default: begin
            // Unused operation codes give zero and pass the flags through.
            rsp.result    = 16'h0000;
            rsp.flags_out = req.flags_in;
         end
      endcase
   end

endmodule

// ===== design/z80_alu_flag_unit_core.sv =====
// Top level of the Z80 ALU flag unit: input register, datapath and result register.
//
// The unit takes one item in every clock cycle and never raises busy. Each item
// is captured in an input register, passes through one combinational datapath
// (8-bit and 16-bit adders, shift network, decimal adjust) and lands in the
// result register. Its result appears on the rsp_ ports, marked by rsp_valid,
// once the result register has captured it. Results leave in the order the
// items came in, one cycle each, and the receiver must take them as they
// appear.
module z80_alu_flag_unit_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  zaf_pkg::zaf_req_type req_item,
   output logic                 rsp_valid,
   output zaf_pkg::zaf_rsp_type rsp_item
);
   import zaf_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   zaf_req_type in_item_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   zaf_rsp_type rsp_item_ff;
   zaf_rsp_type alu_rsp;

   // The pipeline never stalls, so a new item is always welcome.
   assign busy = 1'b0;

   assign in_valid_in  = start && !busy;
   assign rsp_valid_in = in_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (in_valid_in) begin
         in_item_ff <= req_item;
      end
   end

   zaf_alu u_alu (
      .req (in_item_ff),
      .rsp (alu_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_valid_in) begin
         rsp_item_ff <= alu_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Every accepted item yields a result strobe through the input and result registers, and nothing else does.
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      ($past(reset, 1) == 1'b0 && $past(reset, 2) == 1'b0)
      |-> (rsp_valid == $past(start, 2)))
      else $error("result strobe does not match accepted item two cycles earlier");

   // Byte-wide operations give a zero high byte.
   a_byte_result_zero_extended: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start, 2) && $past(req_item.opcode, 2) < OP_ADD16)
      |-> (rsp_item.result[15:8] == 8'h00))
      else $error("byte operation produced a nonzero high byte");

   // Unused operation codes pass the flag byte through and give zero.
   a_unused_op_passthrough: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start, 2) && $past(req_item.opcode, 2) > OP_WIDE)
      |-> (rsp_item.flags_out == $past(req_item.flags_in, 2) && rsp_item.result == 16'h0000))
      else $error("unused operation code altered flags or result");

   // Shifts, rotates and decimal adjust set Z exactly for a zero result.
   a_shift_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start, 2) && $past(req_item.opcode, 2) >= OP_RLC
       && $past(req_item.opcode, 2) <= OP_DAA)
      |-> (rsp_item.flags_out[FLAG_Z] == (rsp_item.result == 16'h0000)))
      else $error("zero flag disagrees with result");

endmodule
